>>> src/tpbf_pkg.sv
// ----------------------------------------------------------------------------
// tpbf_pkg
// Types, constants and helpers shared by the transparent pixel bleed fill.
// ----------------------------------------------------------------------------
package tpbf_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int TILE_WIDTH_W  = 11;
	localparam int TILE_HEIGHT_W = 13;
	localparam int CFG_DATA_W    = 13;
	localparam int CFG_INDEX_W   = 1;

	localparam logic [TILE_WIDTH_W-1:0]  TILE_WIDTH_RST  = 11'd16;
	localparam logic [TILE_HEIGHT_W-1:0] TILE_HEIGHT_RST = 13'd16;

	localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT = 1'b1;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	localparam logic [31:0] GREY_FILL   = 32'h007f7f7f;
	localparam logic [9:0]  RECIP_THREE = 10'd683;

	typedef struct packed {
		logic        action;
		logic [31:0] pixel_in;
	} pixel_req_t;

	typedef struct packed {
		logic [31:0] pixel_out;
		logic [9:0]  out_column;
		logic [11:0] out_row;
		logic        tile_done;
	} pixel_res_t;

	// truncating average of up to four bytes; divide by three via reciprocal
	function automatic logic [7:0] avg_channel(input logic [9:0] sum, input logic [2:0] cnt);
		logic [19:0] prod;
		logic [7:0]  q;
		prod = 20'(sum) * 20'(RECIP_THREE);
		case (cnt)
			3'd1:    q = sum[7:0];
			3'd2:    q = sum[8:1];
			3'd3:    q = prod[18:11];
			3'd4:    q = sum[9:2];
			default: q = 8'h00;
		endcase
		return q;
	endfunction

endpackage

>>> src/transparent_pixel_bleed_fill.sv
// ----------------------------------------------------------------------------
// transparent_pixel_bleed_fill
// Fills transparent pixels of a streamed tile with the average of their
// opaque four-neighbors, one row behind the input.
//
// Usage: pixels of a tile arrive in raster order on the pixel channel
// (valid/ready) with action = pixel; results leave on the result channel
// (valid/ready) one row later. Row 0 gives no results. After the last pixel
// of the tile, send tile_width requests with action = drain to get the final
// row; the last one carries tile_done. Drain requests outside the drain
// phase and pixels during it are taken and dropped.
// Timing: a request that gives a result passes memory read, neighbor gather
// and average steps before its result is registered; a row-0 pixel leaves
// after the gather step, a dropped request never leaves idle. One request
// is in work at a time, so none is taken until the last is through the
// read-gather-average sequence around the two line memories. The result
// register lets the next request be accepted while a result waits; a stalled
// receiver holds the block in its average step until the register frees.
// Reset: registers return to 16 x 16 and the position to the tile start;
// line memories are not cleared. A configuration write also restarts the
// position, and no request is taken in its cycle. Configure only while idle.
// ----------------------------------------------------------------------------
module transparent_pixel_bleed_fill
	import tpbf_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   pixel_valid,
	output logic                   pixel_ready,
	input  pixel_req_t             pixel,
	output logic                   result_valid,
	input  logic                   result_ready,
	output pixel_res_t             result
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int HW = RW + 1;

	typedef enum logic [1:0] {S_IDLE, S_GATHER, S_FILL} state_t;

	state_t                   state_q;
	logic [TILE_WIDTH_W-1:0]  tile_width_q;
	logic [TILE_HEIGHT_W-1:0] tile_height_q;
	logic [CW-1:0]            column_count_q;
	logic [RW-1:0]            row_count_q;
	logic [CW-1:0]            drain_column_q;
	logic                     draining_q;
	logic [31:0]              left_q;
	logic                     result_valid_q;
	pixel_res_t               result_q;

	logic [31:0] pend_mem [MAX_WIDTH];
	logic [31:0] before_mem [MAX_WIDTH];

	// stage 1: latched request and memory read data
	logic [31:0]   px_s1;
	logic [CW-1:0] c_s1;
	logic [RW-1:0] row_s1;
	logic          has_left_s1, has_right_s1, has_up_s1, has_down_s1;
	logic          emit_s1, write_s1, done_s1;
	logic [31:0]   mid_s1, right_s1, up_s1;

	// stage 2: gathered sums
	logic [9:0]    sum_r_s2, sum_g_s2, sum_b_s2;
	logic [2:0]    cnt_s2;
	logic [31:0]   mid_s2;
	logic          mid_opaque_s2;
	logic [CW-1:0] c_s2;
	logic [RW-1:0] row_s2;
	logic          done_s2;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [CW-1:0] c_raw, c_sel, c_next_addr;
	logic          take, accept, last_col, last_row;
	logic          right_ok, left_ok, down_ok, up_ok;
	logic [9:0]    sum_r, sum_g, sum_b;
	logic [2:0]    cnt;
	logic [31:0]   fill_px;
	logic          out_free;

	always_comb begin
		if (tile_width_q == '0)
			w_eff = WW'(1);
		else if (32'(tile_width_q) > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(tile_width_q);
		if (tile_height_q == '0)
			h_eff = HW'(1);
		else if (32'(tile_height_q) > MAX_HEIGHT)
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = HW'(tile_height_q);
	end

	assign c_raw       = (pixel.action == ACT_DRAIN) ? drain_column_q : column_count_q;
	assign c_sel       = (WW'(c_raw) >= w_eff) ? CW'(w_eff - WW'(1)) : c_raw;
	assign c_next_addr = CW'(WW'(c_sel) + WW'(1));
	assign last_col    = (WW'(c_sel) + WW'(1)) >= w_eff;
	assign last_row    = (HW'(row_count_q) + HW'(1)) >= h_eff;
	assign take        = (pixel.action == ACT_DRAIN) ? draining_q : !draining_q;
	assign pixel_ready = (state_q == S_IDLE) && !cfg_we;
	assign accept      = pixel_valid && pixel_ready;

	// line memories
	always_ff @(posedge clk) begin
		if (accept) begin
			mid_s1   <= pend_mem[c_sel];
			right_s1 <= pend_mem[c_next_addr];
			up_s1    <= before_mem[c_sel];
		end
		if (state_q == S_GATHER && write_s1)
			pend_mem[c_s1] <= px_s1;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_GATHER && write_s1 && emit_s1)
			before_mem[c_s1] <= mid_s1;
	end

	// neighbor gather
	always_comb begin
		right_ok = has_right_s1 && (right_s1[31:24] != '0);
		left_ok  = has_left_s1 && (left_q[31:24] != '0);
		down_ok  = has_down_s1 && (px_s1[31:24] != '0);
		up_ok    = has_up_s1 && (up_s1[31:24] != '0);
		sum_r = (right_ok ? 10'(right_s1[23:16]) : 10'd0) + (left_ok ? 10'(left_q[23:16]) : 10'd0)
			+ (down_ok ? 10'(px_s1[23:16]) : 10'd0) + (up_ok ? 10'(up_s1[23:16]) : 10'd0);
		sum_g = (right_ok ? 10'(right_s1[15:8]) : 10'd0) + (left_ok ? 10'(left_q[15:8]) : 10'd0)
			+ (down_ok ? 10'(px_s1[15:8]) : 10'd0) + (up_ok ? 10'(up_s1[15:8]) : 10'd0);
		sum_b = (right_ok ? 10'(right_s1[7:0]) : 10'd0) + (left_ok ? 10'(left_q[7:0]) : 10'd0)
			+ (down_ok ? 10'(px_s1[7:0]) : 10'd0) + (up_ok ? 10'(up_s1[7:0]) : 10'd0);
		cnt = 3'(right_ok) + 3'(left_ok) + 3'(down_ok) + 3'(up_ok);
	end

	// average
	always_comb begin
		if (mid_opaque_s2)
			fill_px = mid_s2;
		else if (cnt_s2 == '0)
			fill_px = GREY_FILL;
		else
			fill_px = {8'h00, avg_channel(sum_r_s2, cnt_s2), avg_channel(sum_g_s2, cnt_s2),
				avg_channel(sum_b_s2, cnt_s2)};
	end

	assign out_free = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			tile_width_q   <= TILE_WIDTH_RST;
			tile_height_q  <= TILE_HEIGHT_RST;
			column_count_q <= '0;
			row_count_q    <= '0;
			drain_column_q <= '0;
			draining_q     <= 1'b0;
			left_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			px_s1          <= '0;
			c_s1           <= '0;
			row_s1         <= '0;
			has_left_s1    <= 1'b0;
			has_right_s1   <= 1'b0;
			has_up_s1      <= 1'b0;
			has_down_s1    <= 1'b0;
			emit_s1        <= 1'b0;
			write_s1       <= 1'b0;
			done_s1        <= 1'b0;
			sum_r_s2       <= '0;
			sum_g_s2       <= '0;
			sum_b_s2       <= '0;
			cnt_s2         <= '0;
			mid_s2         <= '0;
			mid_opaque_s2  <= 1'b0;
			c_s2           <= '0;
			row_s2         <= '0;
			done_s2        <= 1'b0;
		end else begin
			if (state_q == S_FILL && out_free)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_TILE_WIDTH:  tile_width_q  <= cfg_data[TILE_WIDTH_W-1:0];
					REG_TILE_HEIGHT: tile_height_q <= cfg_data[TILE_HEIGHT_W-1:0];
					default: ;
				endcase
				column_count_q <= '0;
				row_count_q    <= '0;
				drain_column_q <= '0;
				draining_q     <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept && take) begin
						state_q      <= S_GATHER;
						px_s1        <= pixel.pixel_in;
						c_s1         <= c_sel;
						has_left_s1  <= (c_sel != '0);
						has_right_s1 <= !last_col;
						if (pixel.action == ACT_DRAIN) begin
							row_s1      <= row_count_q;
							has_up_s1   <= (row_count_q != '0);
							has_down_s1 <= 1'b0;
							emit_s1     <= 1'b1;
							write_s1    <= 1'b0;
							done_s1     <= last_col;
							if (last_col) begin
								column_count_q <= '0;
								row_count_q    <= '0;
								drain_column_q <= '0;
								draining_q     <= 1'b0;
							end else begin
								drain_column_q <= CW'(WW'(c_sel) + WW'(1));
							end
						end else begin
							row_s1      <= row_count_q - RW'(1);
							has_up_s1   <= (HW'(row_count_q) > HW'(1));
							has_down_s1 <= 1'b1;
							emit_s1     <= (row_count_q != '0);
							write_s1    <= 1'b1;
							done_s1     <= 1'b0;
							if (last_col) begin
								column_count_q <= '0;
								if (last_row) begin
									draining_q     <= 1'b1;
									drain_column_q <= '0;
								end else begin
									row_count_q <= row_count_q + RW'(1);
								end
							end else begin
								column_count_q <= CW'(WW'(c_sel) + WW'(1));
							end
						end
					end
				end
				S_GATHER: begin
					left_q        <= mid_s1;
					sum_r_s2      <= sum_r;
					sum_g_s2      <= sum_g;
					sum_b_s2      <= sum_b;
					cnt_s2        <= cnt;
					mid_s2        <= mid_s1;
					mid_opaque_s2 <= (mid_s1[31:24] != '0);
					c_s2          <= c_s1;
					row_s2        <= row_s1;
					done_s2       <= done_s1;
					state_q       <= emit_s1 ? S_FILL : S_IDLE;
				end
				S_FILL: begin
					if (out_free) begin
						result_q.pixel_out   <= fill_px;
						result_q.out_column  <= 10'(c_s2);
						result_q.out_row     <= 12'(row_s2);
						result_q.tile_done   <= done_s2;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_take_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept && take |=> state_q == S_GATHER)
		else $error("accepted request did not start work");

	a_filled_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL && out_free && !mid_opaque_s2 |=> result.pixel_out[31:24] == '0)
		else $error("filled pixel has nonzero alpha");

	a_column_in_tile: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(column_count_q) < w_eff && WW'(drain_column_q) < w_eff)
		else $error("position outside tile width");

	a_drain_at_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> column_count_q == '0)
		else $error("draining with column position not at row start");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams tiles of random pixels through the transparent pixel bleed fill
// over a range of tile shapes, predicts every filled pixel with its own
// two-row line model and checks each result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	import tpbf_pkg::*;

	localparam int RUN_LIMIT = 40000;
	localparam int SETTLE    = 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   pixel_valid = 1'b0;
	logic                   pixel_ready;
	pixel_req_t             pixel = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	pixel_res_t             result;

	transparent_pixel_bleed_fill uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #1 clk = ~clk;

	pixel_req_t pend_q [$];
	pixel_res_t filled_q [$];
	logic       req_taken = 1'b0;
	logic       steady = 1'b0;
	int         cycle_count = 0;
	int         n_errors = 0;
	int         n_sent = 0;
	int         n_checked = 0;
	int         n_shapes = 0;

	// line model
	logic [TILE_WIDTH_W-1:0]  width_reg = TILE_WIDTH_RST;
	logic [TILE_HEIGHT_W-1:0] height_reg = TILE_HEIGHT_RST;
	logic [31:0] row_two_up [MAX_WIDTH_DEF];
	logic [31:0] row_one_up [MAX_WIDTH_DEF];
	logic [31:0] left_up_px = '0;
	int          col_pos = 0;
	int          row_pos = 0;
	int          drain_pos = 0;
	logic        in_drain = 1'b0;

	function automatic int clamp_width(input int w);
		if (w == 0)
			return 1;
		if (w > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return w;
	endfunction

	function automatic int clamp_height(input int h);
		if (h == 0)
			return 1;
		if (h > MAX_HEIGHT_DEF)
			return MAX_HEIGHT_DEF;
		return h;
	endfunction

	// neighbors: [0] left, [1] right, [2] down, [3] up
	function automatic logic [31:0] bleed_pixel(input logic [31:0] self_px,
			input logic [3:0] have, input logic [3:0][31:0] nb);
		int sr = 0;
		int sg = 0;
		int sb = 0;
		int n = 0;
		int k;
		if (self_px[31:24] != 8'h00)
			return self_px;
		for (k = 0; k < 4; k++) begin
			if (have[k] && nb[k][31:24] != 8'h00) begin
				sr += nb[k][23:16];
				sg += nb[k][15:8];
				sb += nb[k][7:0];
				n++;
			end
		end
		if (n == 0)
			return GREY_FILL;
		return {8'h00, 8'(sr / n), 8'(sg / n), 8'(sb / n)};
	endfunction

	function automatic void restart_tile();
		col_pos = 0;
		row_pos = 0;
		drain_pos = 0;
		in_drain = 1'b0;
	endfunction

	task automatic fill_predict(input pixel_req_t rq);
		int w;
		int h;
		int c;
		logic [31:0] mid;
		logic [31:0] right_px;
		logic [3:0] have;
		logic [3:0][31:0] nb;
		pixel_res_t r;
		w = clamp_width(int'(width_reg));
		h = clamp_height(int'(height_reg));
		if (rq.action == ACT_DRAIN) begin
			if (!in_drain)
				return;
			c = (drain_pos >= w) ? w - 1 : drain_pos;
			right_px = (c + 1 < w) ? row_one_up[c + 1] : 32'h0;
			have = {row_pos > 0, 1'b0, c + 1 < w, c > 0};
			nb = {row_two_up[c], 32'h0, right_px, (c > 0) ? row_one_up[c - 1] : 32'h0};
			r.pixel_out = bleed_pixel(row_one_up[c], have, nb);
			r.out_column = 10'(c);
			r.out_row = 12'(row_pos);
			r.tile_done = (c + 1 >= w);
			filled_q.insert(filled_q.size(), r);
			if (r.tile_done)
				restart_tile();
			else
				drain_pos = c + 1;
			return;
		end
		if (in_drain)
			return;
		c = (col_pos >= w) ? w - 1 : col_pos;
		if (row_pos > 0) begin
			mid = row_one_up[c];
			right_px = (c + 1 < w) ? row_one_up[c + 1] : 32'h0;
			have = {row_pos > 1, 1'b1, c + 1 < w, c > 0};
			nb = {row_two_up[c], rq.pixel_in, right_px, left_up_px};
			r.pixel_out = bleed_pixel(mid, have, nb);
			r.out_column = 10'(c);
			r.out_row = 12'(row_pos - 1);
			r.tile_done = 1'b0;
			filled_q.insert(filled_q.size(), r);
			row_two_up[c] = mid;
			left_up_px = mid;
		end
		row_one_up[c] = rq.pixel_in;
		if (c + 1 >= w) begin
			col_pos = 0;
			if (row_pos + 1 >= h) begin
				in_drain = 1'b1;
				drain_pos = 0;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		$display("mismatch %s at cycle %0d: got %h, expected %h", what, cycle_count, got, want);
	endtask

	always @(posedge clk) begin : check_results
		pixel_res_t want;
		req_taken <= pixel_valid && pixel_ready;
		if (arst_n && result_valid && result_ready) begin
			if (filled_q.size() == 0) begin
				report_mismatch("result with nothing expected", result.pixel_out, 32'h0);
			end else begin
				want = filled_q.pop_front();
				n_checked++;
				if (result.pixel_out !== want.pixel_out)
					report_mismatch("pixel_out", result.pixel_out, want.pixel_out);
				if (result.out_column !== want.out_column)
					report_mismatch("out_column", 32'(result.out_column), 32'(want.out_column));
				if (result.out_row !== want.out_row)
					report_mismatch("out_row", 32'(result.out_row), 32'(want.out_row));
				if (result.tile_done !== want.tile_done)
					report_mismatch("tile_done", 32'(result.tile_done), 32'(want.tile_done));
			end
		end
		if (arst_n && pixel_valid && pixel_ready) begin
			fill_predict(pixel);
			n_sent++;
		end
	end

	always @(negedge clk) begin
		if (pixel_valid && !req_taken) begin
			// hold the request until it is taken
		end else if (pend_q.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
			pixel <= pend_q.pop_front();
			pixel_valid <= 1'b1;
		end else begin
			pixel_valid <= 1'b0;
		end
		result_ready <= steady || $urandom_range(99) >= 18;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				filled_q.size());
			$display("** transparent_pixel_bleed_fill: FAILED **");
			$finish;
		end
	end

	task automatic push_item(input logic act, input logic [31:0] px);
		pixel_req_t rq;
		rq.action = act;
		rq.pixel_in = px;
		pend_q.insert(pend_q.size(), rq);
	endtask

	function automatic logic [31:0] random_pixel();
		case ($urandom_range(9))
			0, 1, 2, 3: return {8'h00, 24'($urandom())};
			4:          return {8'hff, 24'($urandom())};
			5:          return $urandom_range(1) ? 32'h00ffffff : 32'h00000000;
			6:          return $urandom();
			default:    return {8'($urandom_range(255, 1)), 24'($urandom())};
		endcase
	endfunction

	task automatic settle();
		do
			@(posedge clk);
		while (pend_q.size() != 0 || pixel_valid || filled_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TILE_WIDTH)
			width_reg = val[TILE_WIDTH_W-1:0];
		else
			height_reg = val[TILE_HEIGHT_W-1:0];
		restart_tile();
	endtask

	// one tile with stray requests mixed in; cut >= 0 stops it after that many pixels
	task automatic queue_tile(input int w, input int h, input int cut);
		int i;
		for (i = 0; i < w * h; i++) begin
			if (cut >= 0 && i == cut)
				return;
			if ($urandom_range(19) == 0)
				push_item(ACT_DRAIN, $urandom());
			push_item(ACT_PIXEL, random_pixel());
		end
		for (i = 0; i < w; i++) begin
			if ($urandom_range(19) == 0)
				push_item(ACT_PIXEL, random_pixel());
			push_item(ACT_DRAIN, $urandom());
		end
		if ($urandom_range(3) == 0)
			push_item(ACT_DRAIN, $urandom());
	endtask

	task automatic run_shape(input int w_reg, input int h_reg, input int tiles, input int cut);
		int w;
		int h;
		int t;
		settle();
		cfg_write(REG_TILE_WIDTH, CFG_DATA_W'(w_reg));
		cfg_write(REG_TILE_HEIGHT, CFG_DATA_W'(h_reg));
		w = clamp_width(w_reg);
		h = clamp_height(h_reg);
		for (t = 0; t < tiles; t++)
			queue_tile(w, h, -1);
		if (cut >= 0)
			queue_tile(w, h, cut);
		n_shapes++;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// stray drain, then part of row 0 of the reset-size tile
		push_item(ACT_DRAIN, 32'ha5a55a5a);
		push_item(ACT_PIXEL, 32'h00000000);
		push_item(ACT_PIXEL, 32'hffffffff);
		settle();
		// bits above the width register are dropped
		cfg_write(REG_TILE_WIDTH, 13'h1803);
		cfg_write(REG_TILE_HEIGHT, 13'd2);
		push_item(ACT_PIXEL, 32'hff000000);
		push_item(ACT_PIXEL, 32'h00ffffff);
		push_item(ACT_PIXEL, 32'h01abcdef);
		push_item(ACT_PIXEL, 32'h00000000);
		push_item(ACT_PIXEL, 32'h00123456);
		push_item(ACT_PIXEL, 32'h80ffffff);
		push_item(ACT_PIXEL, 32'h5a5aa5a5);
		push_item(ACT_DRAIN, 32'h00000000);
		push_item(ACT_DRAIN, 32'hffffffff);
		push_item(ACT_DRAIN, 32'h12345678);
		push_item(ACT_DRAIN, 32'h87654321);
		settle();
		// zero registers act as a 1 x 1 tile
		cfg_write(REG_TILE_WIDTH, 13'd0);
		cfg_write(REG_TILE_HEIGHT, 13'd0);
		push_item(ACT_PIXEL, 32'h00000000);
		push_item(ACT_DRAIN, 32'h00000000);
		push_item(ACT_PIXEL, 32'h7f000001);
		push_item(ACT_DRAIN, 32'hffffffff);
		n_shapes += 2;

		steady = 1'b1;
		run_shape(16, 16, 1, -1);
		settle();
		steady = 1'b0;
		run_shape(5, 3, 2, -1);
		run_shape(1, 5, 4, -1);
		run_shape(7, 1, 3, -1);
		run_shape(2, 2, 5, -1);
		run_shape(9, 4, 1, 10);
		run_shape(2047, 1, 0, 24);
		run_shape(0, 8191, 0, 24);
		run_shape(1024, 4096, 0, 24);
		run_shape(4, 6, 1, -1);
		run_shape(1, 1, 3, -1);
		run_shape(3, 8, 1, 5);
		run_shape(2, 1, 4, -1);
		settle();
		repeat (20) @(posedge clk);

		$display("bleed fill: %0d requests taken, %0d pixels checked over %0d tile shapes",
			n_sent, n_checked, n_shapes);
		$display("register values ran from zero up past the widest and tallest tile; %0d mismatches",
			n_errors);
		if (n_errors == 0)
			$display("** transparent_pixel_bleed_fill: PASSED **");
		else
			$display("** transparent_pixel_bleed_fill: FAILED **");
		$finish;
	end

endmodule

>>> files.f
src/tpbf_pkg.sv
src/transparent_pixel_bleed_fill.sv
verif/testbench.sv
